@@ hw/rtl/sct_pkg.sv @@
// Package for the source code tokenizer: token kinds, scan modes, sizes
// and the character-class and keyword functions. No dependencies.
`default_nettype none

package sct_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LEN_BITS        = 16;
    localparam int KIND_BITS       = 5;
    localparam int KW_DEPTH        = 6;
    localparam int Q_DEPTH         = 4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_INT   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_DROP  = 2'd3
    } t_mode;

    localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_INTEGER = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_INT_KW  = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_RETURN  = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_IF      = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_ELSE    = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_WHILE   = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_ERROR   = 5'd18;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;

    // Keyword spellings, first character in the lowest byte.
    localparam logic [8*KW_DEPTH-1:0] KW_INT    = {8'h00, 8'h00, 8'h00, "t", "n", "i"};
    localparam logic [8*KW_DEPTH-1:0] KW_RETURN = {"n", "r", "u", "t", "e", "r"};
    localparam logic [8*KW_DEPTH-1:0] KW_IF     = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};
    localparam logic [8*KW_DEPTH-1:0] KW_ELSE   = {8'h00, 8'h00, "e", "s", "l", "e"};
    localparam logic [8*KW_DEPTH-1:0] KW_WHILE  = {8'h00, "e", "l", "i", "h", "w"};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Punctuator kind, or the error kind for any byte that is no punctuator.
    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "=":     k = KIND_ASSIGN;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // True when the stored bytes below klen spell the given keyword.
    function automatic logic kw_match(input logic [8*KW_DEPTH-1:0] chars,
                                      input logic [8*KW_DEPTH-1:0] text,
                                      input int unsigned klen);
        logic m;
        m = 1'b1;
        for (int i = 0; i < KW_DEPTH; i++) begin
            if (i < klen && chars[8*i +: 8] != text[8*i +: 8]) m = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [KIND_BITS-1:0] ident_kind(input logic [8*KW_DEPTH-1:0] chars,
                                                         input logic [LEN_BITS-1:0] len);
        logic [KIND_BITS-1:0] k;
        k = KIND_IDENT;
        if (len == LEN_BITS'(3) && kw_match(chars, KW_INT, 3)) k = KIND_INT_KW;
        else if (len == LEN_BITS'(6) && kw_match(chars, KW_RETURN, 6)) k = KIND_RETURN;
        else if (len == LEN_BITS'(2) && kw_match(chars, KW_IF, 2)) k = KIND_IF;
        else if (len == LEN_BITS'(4) && kw_match(chars, KW_ELSE, 4)) k = KIND_ELSE;
        else if (len == LEN_BITS'(5) && kw_match(chars, KW_WHILE, 5)) k = KIND_WHILE;
        return k;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/source_code_tokenizer.sv @@
// Top level of the source code tokenizer: scanner state, token building
// and a small token queue toward the output stream. Depends on sct_pkg.
`default_nettype none

// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+--------------------------------------
// s (bytes) | in  | i_s_tvalid / o_s_tready    | i_s_tdata: text byte
// m (token) | out | o_m_tvalid / i_m_tready    | o_m_tdata: kind, line, column, offset,
//           |     |                            | length; o_m_tlast: last token of byte
//
// One byte is taken in every cycle while ready: the scanner decides everything
// about a byte in the cycle of its transfer and writes up to two tokens into a
// four-entry queue. The sustained rate is set by the output port, which drains one
// token a cycle while i_m_tready is high; a byte that closes one token and starts
// a punctuator, error token or end of text makes two. The input is ready while
// the queue holds at most two tokens, so with the output stalled it stops once more
// than two tokens wait; bytes that make no token do not fill it. Reset is synchronous,
// active low, and returns every position counter to line 1, column 1, offset 0.

module source_code_tokenizer
    import sct_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // Fields from the lowest bit: text_byte.
    input  wire logic [7:0]            i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // Fields from the lowest bit: token_kind, start_line, start_column,
    // start_offset, token_length, then zero fill up to a whole byte.
    output logic [((KIND_BITS + 2*LINE_BITS + OFFSET_BITS + LEN_BITS + 7) / 8) * 8 - 1:0]
                                       o_m_tdata,
    output logic                       o_m_tlast
);

    localparam int TOK_BITS = KIND_BITS + 2*LINE_BITS + OFFSET_BITS + LEN_BITS;
    localparam int TDATA_W  = ((TOK_BITS + 7) / 8) * 8;
    localparam int ENT_BITS = TOK_BITS + 1;
    localparam int PTR_BITS = $clog2(Q_DEPTH);
    localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

    // Scanner state.
    t_mode                    r_mode, n_mode;
    logic [LINE_BITS-1:0]     r_line, n_line;
    logic [LINE_BITS-1:0]     r_col, n_col;
    logic [OFFSET_BITS-1:0]   r_off, n_off;
    logic [LINE_BITS-1:0]     r_tok_line, n_tok_line;
    logic [LINE_BITS-1:0]     r_tok_col, n_tok_col;
    logic [OFFSET_BITS-1:0]   r_tok_off, n_tok_off;
    logic [LEN_BITS-1:0]      r_tok_len, n_tok_len;
    logic [8*KW_DEPTH-1:0]    r_kw, n_kw;

    // Token queue.
    logic [ENT_BITS-1:0]      r_q [Q_DEPTH];
    logic [PTR_BITS-1:0]      r_wr, r_rd;
    logic [CNT_BITS-1:0]      r_cnt;

    logic                     s_xfer, m_xfer;
    logic [7:0]               c;
    logic [1:0]               push;
    logic [ENT_BITS-1:0]      tok0, tok1;

    // Position after the current byte, with saturation.
    logic [LINE_BITS-1:0]     adv_line, adv_col;
    logic [OFFSET_BITS-1:0]   adv_off;
    logic [LEN_BITS-1:0]      inc_len;

    function automatic logic [TOK_BITS-1:0] pack_tok(
        input logic [KIND_BITS-1:0]   kind,
        input logic [LINE_BITS-1:0]   ln,
        input logic [LINE_BITS-1:0]   col,
        input logic [OFFSET_BITS-1:0] off,
        input logic [LEN_BITS-1:0]    len
    );
        return {len, off, col, ln, kind};
    endfunction

    assign c          = i_s_tdata;
    assign o_s_tready = (r_cnt <= CNT_BITS'(Q_DEPTH - 2));
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != '0);
    assign m_xfer     = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = TDATA_W'(r_q[r_rd][TOK_BITS-1:0]);
    assign o_m_tlast  = r_q[r_rd][TOK_BITS];

    always_comb begin
        if (c == CHAR_NEWLINE) begin
            adv_line = (&r_line) ? r_line : r_line + LINE_BITS'(1);
            adv_col  = LINE_BITS'(1);
        end else begin
            adv_line = r_line;
            adv_col  = (&r_col) ? r_col : r_col + LINE_BITS'(1);
        end
        adv_off = (&r_off) ? r_off : r_off + OFFSET_BITS'(1);
        inc_len = (&r_tok_len) ? r_tok_len : r_tok_len + LEN_BITS'(1);
    end

    // Lexing of one byte. A byte that ends an open token first closes it, then
    // is lexed as if the scanner were between tokens.
    always_comb begin
        logic                 closed;
        logic [KIND_BITS-1:0] pk;
        n_mode     = r_mode;
        n_line     = r_line;
        n_col      = r_col;
        n_off      = r_off;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_off  = r_tok_off;
        n_tok_len  = r_tok_len;
        n_kw       = r_kw;
        push       = 2'd0;
        tok0       = '0;
        tok1       = '0;
        closed     = 1'b0;
        pk         = punct_kind(c);

        case (r_mode)
            MODE_DROP: begin
                if (c == CHAR_NUL) begin
                    n_mode     = MODE_IDLE;
                    n_line     = LINE_BITS'(1);
                    n_col      = LINE_BITS'(1);
                    n_off      = '0;
                    n_tok_line = LINE_BITS'(1);
                    n_tok_col  = LINE_BITS'(1);
                    n_tok_off  = '0;
                    n_tok_len  = '0;
                end
            end
            MODE_INT: begin
                if (is_digit(c)) begin
                    n_tok_len = inc_len;
                    n_line    = adv_line;
                    n_col     = adv_col;
                    n_off     = adv_off;
                end else begin
                    closed = 1'b1;
                    tok0   = {1'b0, pack_tok(KIND_INTEGER, r_tok_line, r_tok_col,
                                             r_tok_off, r_tok_len)};
                end
            end
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == CHAR_UNDER) begin
                    for (int i = 0; i < KW_DEPTH; i++) begin
                        if (r_tok_len == LEN_BITS'(i)) n_kw[8*i +: 8] = c;
                    end
                    n_tok_len = inc_len;
                    n_line    = adv_line;
                    n_col     = adv_col;
                    n_off     = adv_off;
                end else begin
                    closed = 1'b1;
                    tok0   = {1'b0, pack_tok(ident_kind(r_kw, r_tok_len), r_tok_line,
                                             r_tok_col, r_tok_off, r_tok_len)};
                end
            end
            default: ;
        endcase

        if (r_mode == MODE_IDLE || closed) begin
            logic [ENT_BITS-1:0] t;
            logic                emit;
            t    = '0;
            emit = 1'b0;
            n_mode = MODE_IDLE;
            if (c == CHAR_NUL) begin
                // End of text: report the current position, then start over.
                emit       = 1'b1;
                t          = {1'b1, pack_tok(KIND_EOF, r_line, r_col, r_off, '0)};
                n_line     = LINE_BITS'(1);
                n_col      = LINE_BITS'(1);
                n_off      = '0;
                n_tok_line = LINE_BITS'(1);
                n_tok_col  = LINE_BITS'(1);
                n_tok_off  = '0;
                n_tok_len  = '0;
            end else if (is_space(c)) begin
                n_line = adv_line;
                n_col  = adv_col;
                n_off  = adv_off;
            end else if (is_digit(c) || is_letter(c) || c == CHAR_UNDER) begin
                n_tok_line = r_line;
                n_tok_col  = r_col;
                n_tok_off  = r_off;
                n_tok_len  = LEN_BITS'(1);
                if (is_digit(c)) begin
                    n_mode = MODE_INT;
                end else begin
                    n_mode       = MODE_IDENT;
                    n_kw[7:0]    = c;
                end
                n_line = adv_line;
                n_col  = adv_col;
                n_off  = adv_off;
            end else begin
                // Punctuator or unknown byte; an unknown byte starts dropping.
                emit = 1'b1;
                t    = {1'b1, pack_tok(pk, r_line, r_col, r_off, LEN_BITS'(1))};
                if (pk == KIND_ERROR) n_mode = MODE_DROP;
                n_line = adv_line;
                n_col  = adv_col;
                n_off  = adv_off;
            end

            if (closed) begin
                if (emit) begin
                    tok1 = t;
                    push = 2'd2;
                end else begin
                    tok0[TOK_BITS] = 1'b1;
                    push = 2'd1;
                end
            end else if (emit) begin
                tok0 = t;
                push = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_line     <= LINE_BITS'(1);
            r_col      <= LINE_BITS'(1);
            r_off      <= '0;
            r_tok_line <= LINE_BITS'(1);
            r_tok_col  <= LINE_BITS'(1);
            r_tok_off  <= '0;
            r_tok_len  <= '0;
        end else if (s_xfer) begin
            r_mode     <= n_mode;
            r_line     <= n_line;
            r_col      <= n_col;
            r_off      <= n_off;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_off  <= n_tok_off;
            r_tok_len  <= n_tok_len;
        end
    end

    // Keyword bytes are only read below the open length, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (s_xfer) r_kw <= n_kw;
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && push != 2'd0) begin
            r_q[r_wr] <= tok0;
            if (push == 2'd2) r_q[r_wr + PTR_BITS'(1)] <= tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_xfer) r_wr <= r_wr + PTR_BITS'(push);
            if (m_xfer) r_rd <= r_rd + PTR_BITS'(1);
            r_cnt <= r_cnt + CNT_BITS'(s_xfer ? push : 2'd0) - CNT_BITS'(m_xfer);
        end
    end

endmodule

`default_nettype wire

@@ test/token_stream_checker.sv @@
`timescale 1ns / 1ps
// Token stream checker for the source code tokenizer: watches both stream channels,
// predicts the tokens from the accepted text bytes and compares them. Depends on sct_pkg.

module token_stream_checker
    import sct_pkg::*;
#(
    parameter int TDATA_W = 80
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    // Fields from the lowest bit: text_byte.
    input  wire logic [7:0]         i_s_tdata,
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    // Fields from the lowest bit: token_kind, start_line, start_column,
    // start_offset, token_length, zero fill.
    input  wire logic [TDATA_W-1:0] i_m_tdata,
    input  wire logic               i_m_tlast,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_bytes_seen,
    output int                      o_tokens_seen
);

    localparam int LW = LINE_BITS_DEF;
    localparam int OW = OFFSET_BITS_DEF;

    localparam int LINE_LSB = KIND_BITS;
    localparam int COL_LSB  = KIND_BITS + LW;
    localparam int OFF_LSB  = KIND_BITS + 2 * LW;
    localparam int LEN_LSB  = KIND_BITS + 2 * LW + OW;

    // Punctuators in kind order, the plus sign in the highest byte.
    localparam logic [79:0] PUNCT_TEXT = "+-*/();{}=";

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [LW-1:0]        line;
        logic [LW-1:0]        column;
        logic [OW-1:0]        offset;
        logic [LEN_BITS-1:0]  length;
        logic                 last;
    } token_rec_t;

    token_rec_t expected_tokens[$];

    // Scanner state: the next byte's position and the token being built.
    t_mode                 scan_mode;
    logic [LW-1:0]         cur_line;
    logic [LW-1:0]         cur_col;
    logic [OW-1:0]         cur_off;
    logic [LW-1:0]         tok_line;
    logic [LW-1:0]         tok_col;
    logic [OW-1:0]         tok_off;
    logic [LEN_BITS-1:0]   tok_len;
    logic [8*KW_DEPTH-1:0] tok_head;

    int fail_count    = 0;
    int pending_count = 0;
    int bytes_seen    = 0;
    int tokens_seen   = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_count;
    assign o_bytes_seen  = bytes_seen;
    assign o_tokens_seen = tokens_seen;

    function automatic logic char_is_numeral(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic char_is_word_start(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], CHAR_UNDER};
    endfunction

    function automatic logic char_is_blank(input logic [7:0] c);
        return c inside {" ", [8'h09:8'h0D]};
    endfunction

    function automatic void reset_scanner();
        scan_mode = MODE_IDLE;
        cur_line  = LW'(1);
        cur_col   = LW'(1);
        cur_off   = '0;
        tok_line  = LW'(1);
        tok_col   = LW'(1);
        tok_off   = '0;
        tok_len   = '0;
        tok_head  = '0;
    endfunction

    // Moves the position past one byte; all counters stop at their maxima.
    function automatic void step_position(input logic [7:0] c);
        if (c == CHAR_NEWLINE) begin
            if (cur_line != '1) cur_line = cur_line + 1'b1;
            cur_col = LW'(1);
        end else if (cur_col != '1) begin
            cur_col = cur_col + 1'b1;
        end
        if (cur_off != '1) cur_off = cur_off + 1'b1;
    endfunction

    function automatic void open_token();
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_off  = cur_off;
        tok_len  = LEN_BITS'(1);
    endfunction

    function automatic void bump_length();
        if (tok_len != '1) tok_len = tok_len + 1'b1;
    endfunction

    function automatic token_rec_t make_token(input logic [KIND_BITS-1:0] kind,
                                              input logic [LW-1:0] line,
                                              input logic [LW-1:0] column,
                                              input logic [OW-1:0] offset,
                                              input logic [LEN_BITS-1:0] length);
        token_rec_t t;
        t.kind   = kind;
        t.line   = line;
        t.column = column;
        t.offset = offset;
        t.length = length;
        t.last   = 1'b0;
        return t;
    endfunction

    // The head bytes above the length are zero, so a whole-vector compare
    // against the zero-filled spellings is exact. Longer words never match.
    function automatic logic [KIND_BITS-1:0] word_kind();
        logic [KIND_BITS-1:0] k;
        k = KIND_IDENT;
        case (tok_len)
            LEN_BITS'(2): if (tok_head == KW_IF) k = KIND_IF;
            LEN_BITS'(3): if (tok_head == KW_INT) k = KIND_INT_KW;
            LEN_BITS'(4): if (tok_head == KW_ELSE) k = KIND_ELSE;
            LEN_BITS'(5): if (tok_head == KW_WHILE) k = KIND_WHILE;
            LEN_BITS'(6): if (tok_head == KW_RETURN) k = KIND_RETURN;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // Lexes one accepted byte and queues the tokens it closes or makes.
    function automatic void lex_byte(input logic [7:0] c);
        token_rec_t made [2];
        int n;
        logic [KIND_BITS-1:0] pk;
        n = 0;
        if (scan_mode == MODE_DROP) begin
            if (c == CHAR_NUL) reset_scanner();
            return;
        end
        if (scan_mode == MODE_INT) begin
            if (char_is_numeral(c)) begin
                bump_length();
                step_position(c);
                return;
            end
            made[n] = make_token(KIND_INTEGER, tok_line, tok_col, tok_off, tok_len);
            n++;
            scan_mode = MODE_IDLE;
        end else if (scan_mode == MODE_IDENT) begin
            if (char_is_word_start(c) || char_is_numeral(c)) begin
                if (tok_len < KW_DEPTH) tok_head[8*tok_len +: 8] = c;
                bump_length();
                step_position(c);
                return;
            end
            made[n] = make_token(word_kind(), tok_line, tok_col, tok_off, tok_len);
            n++;
            scan_mode = MODE_IDLE;
        end

        if (c == CHAR_NUL) begin
            made[n] = make_token(KIND_EOF, cur_line, cur_col, cur_off, '0);
            n++;
            reset_scanner();
        end else if (char_is_blank(c)) begin
            step_position(c);
        end else if (char_is_numeral(c)) begin
            open_token();
            scan_mode = MODE_INT;
            step_position(c);
        end else if (char_is_word_start(c)) begin
            open_token();
            tok_head      = '0;
            tok_head[7:0] = c;
            scan_mode     = MODE_IDENT;
            step_position(c);
        end else begin
            pk = KIND_ERROR;
            for (int k = 0; k < 10; k++) begin
                if (PUNCT_TEXT[8*(9-k) +: 8] == c) pk = KIND_BITS'(KIND_PLUS + k);
            end
            made[n] = make_token(pk, cur_line, cur_col, cur_off, LEN_BITS'(1));
            n++;
            if (pk == KIND_ERROR) scan_mode = MODE_DROP;
            step_position(c);
        end

        for (int i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            expected_tokens.push_back(made[i]);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Outputs come from the block's registers, so the token leaving at this
    // edge never belongs to the byte entering at the same edge.
    always @(posedge i_clk) begin : sample_channels
        token_rec_t want;
        if (!i_rst_n) begin
            reset_scanner();
            expected_tokens.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $error("token transfer with none expected: kind %0d, offset %0d",
                           i_m_tdata[KIND_BITS-1:0], i_m_tdata[OFF_LSB +: OW]);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, i_m_tdata[KIND_BITS-1:0]);
                    check_field("start_line", want.line, i_m_tdata[LINE_LSB +: LW]);
                    check_field("start_column", want.column, i_m_tdata[COL_LSB +: LW]);
                    check_field("start_offset", want.offset, i_m_tdata[OFF_LSB +: OW]);
                    check_field("token_length", want.length,
                                i_m_tdata[LEN_LSB +: LEN_BITS]);
                    check_field("last_of_run", want.last, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                bytes_seen++;
                lex_byte(i_s_tdata);
            end
        end
        pending_count = expected_tokens.size();
    end

endmodule

@@ test/source_code_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the source code tokenizer: clock, reset, text stimulus, output
// back-pressure and the verdict. Depends on sct_pkg and token_stream_checker.

module source_code_tokenizer_tb;
    import sct_pkg::*;

    localparam int TDATA_W = ((KIND_BITS + 2*LINE_BITS_DEF + OFFSET_BITS_DEF + LEN_BITS + 7)
                              / 8) * 8;
    // The longest silent stretch in a correct run is the long receiver hold,
    // with the input stalled behind the token queue; the limit is several times that.
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [TDATA_W-1:0]  o_m_tdata;
    logic                o_m_tlast;

    int fail_count;
    int pending;
    int bytes_seen;
    int tokens_seen;

    int src_idle_pct  = 0;
    int dst_idle_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int counted_bytes = 0;
    int quiet_cycles  = 0;

    source_code_tokenizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    token_stream_checker #(
        .TDATA_W (TDATA_W)
    ) u_token_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_bytes_seen  (bytes_seen),
        .o_tokens_seen (tokens_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Any cycle without a transfer on either channel counts toward the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                for (int i = 0; i < HOLD_CYCLES; i++) begin
                    i_m_tready <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                i_m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Offers one byte, with random idle cycles in front, and returns after its transfer.
    task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (counted) counted_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Sender pause: nothing offered until every predicted token has left.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic string keyword_text(input int idx);
        case (idx)
            0:       return "int";
            1:       return "return";
            2:       return "if";
            3:       return "else";
            default: return "while";
        endcase
    endfunction

    function automatic logic [7:0] word_char(input bit allow_digit);
        int r;
        r = $urandom_range(0, allow_digit ? 62 : 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return CHAR_UNDER;
        return 8'("0" + r - 53);
    endfunction

    // Mostly spaces and newlines, now and then the rarer C whitespace bytes.
    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return " ";
            4, 5:       return CHAR_NEWLINE;
            6:          return 8'h09;
            7:          return 8'h0B;
            8:          return 8'h0C;
            default:    return 8'h0D;
        endcase
    endfunction

    // A byte that no token can start: high half, stray ASCII or control codes.
    function automatic logic [7:0] error_byte();
        string odd;
        odd = "#!%&,.<>?@[]^`|~$:'\"\\";
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(128, 255));
            1:       return odd[$urandom_range(0, odd.len() - 1)];
            2:       return 8'($urandom_range(14, 31));
            default: return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_identifier(input int len);
        send_byte(word_char(1'b0));
        repeat (len - 1) send_byte(word_char(1'b1));
    endtask

    // One text: mostly well-formed tokens with random spacing, sometimes
    // broken by a bad byte and the dropped tail behind it, sometimes pure noise.
    task automatic send_program();
        int ntok;
        int len;
        string w;
        string punct;
        punct = "+-*/();{}=";
        if ($urandom_range(99) < 8) begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(8'($urandom_range(1, 255)));
            send_byte(CHAR_NUL);
            return;
        end
        ntok = $urandom_range(1, 10);
        repeat (ntok) begin
            case ($urandom_range(0, 9))
                0, 1: send_text(keyword_text($urandom_range(0, 4)));
                2: begin
                    // A keyword one byte short or one byte long stays an identifier.
                    w = keyword_text($urandom_range(0, 4));
                    if ($urandom_range(0, 1) != 0) begin
                        send_text(w.substr(0, w.len() - 2));
                    end else begin
                        send_text(w);
                        send_byte(word_char(1'b1));
                    end
                end
                3, 4: send_identifier(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                                 : $urandom_range(1, 6));
                5: begin
                    len = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(1, 6);
                    repeat (len) send_byte(8'("0" + $urandom_range(0, 9)));
                end
                6, 7, 8: send_byte(punct[$urandom_range(0, 9)]);
                default: repeat ($urandom_range(1, 3)) send_byte(blank_byte());
            endcase
            if ($urandom_range(99) < 55) send_byte(blank_byte());
            if ($urandom_range(99) < 4) begin
                send_byte(error_byte());
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)), 1'b0);
                send_byte(CHAR_NUL, 1'b0);
                return;
            end
        end
        send_byte(CHAR_NUL);
    endtask

    task automatic run_random(input int target);
        while (counted_bytes < target) send_program();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles a little, receiver a lot.
        src_idle_pct = 22;
        dst_idle_pct = 63;
        // Every keyword and punctuator, a word starting with an underscore, an
        // integer closed by a punctuator, and an identifier closed by end of text.
        send_text("int+return-if*else/while(_9)7;{}=z");
        send_byte(CHAR_NUL);
        // Bad bytes at both ends of the high half; the middle one is dropped.
        send_byte(8'hFF);
        send_byte(8'h80, 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_byte(8'h80);
        send_byte(CHAR_NUL, 1'b0);
        run_random(370);
        wait_drained();

        // Phase two: the other way round, opened by a long receiver hold-off.
        src_idle_pct = 63;
        dst_idle_pct = 22;
        hold_requests++;
        run_random(720);
        wait_drained();

        // Phase three: no idling, another hold-off with the sender at full rate.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_requests++;
        run_random(1050);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Lexed %0d text bytes (%0d in total) and checked %0d tokens,", counted_bytes,
                 bytes_seen, tokens_seen);
        $display("covering all token kinds, error recovery and long output stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
